// ----- hdl/lrc_pkg.sv -----
`default_nettype none

package lrc_pkg;

  // Byte codes that the scanner reacts to.
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChBs = 8'h5C;

  // Result kinds as they appear on the output.
  localparam logic [1:0] KindChar = 2'd0;
  localparam logic [1:0] KindEol  = 2'd1;
  localparam logic [1:0] KindDone = 2'd2;

  localparam int unsigned MaxCharsWidth = 16;
  localparam logic [MaxCharsWidth-1:0] MaxCharsReset = 16'd1023;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_CR     = 4'b0010,
    MODE_BS     = 4'b0100,
    MODE_BS_CR  = 4'b1000
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/lrc_scan.sv -----
`default_nettype none

module lrc_scan #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic [7:0]                          byte_i,
  input  wire logic                                eof_i,
  input  wire lrc_pkg::scan_mode_e                 mode_i,
  input  wire logic [COUNT_BITS-1:0]               count_i,
  input  wire logic [lrc_pkg::MaxCharsWidth-1:0]   max_chars_i,
  output lrc_pkg::scan_mode_e                      mode_o,
  output logic [COUNT_BITS-1:0]                    count_o,
  output logic [1:0]                               num_o,
  output lrc_pkg::result_t                         res0_o,
  output lrc_pkg::result_t                         res1_o
);

  localparam int unsigned CmpWidth =
      (COUNT_BITS > lrc_pkg::MaxCharsWidth) ? COUNT_BITS : lrc_pkg::MaxCharsWidth;

  logic can_keep;
  logic normal_path;
  logic keep;
  logic close_line;

  // A character is kept only below both the register limit and counter saturation.
  assign can_keep = (CmpWidth'(count_i) < CmpWidth'(max_chars_i)) && (count_i != '1);

  always_comb begin
    mode_o      = mode_i;
    count_o     = count_i;
    num_o       = 2'd0;
    res0_o      = '0;
    res1_o      = '0;
    normal_path = 1'b0;
    keep        = 1'b0;
    close_line  = 1'b0;

    if (eof_i) begin
      close_line = (mode_i == lrc_pkg::MODE_BS) || (mode_i == lrc_pkg::MODE_BS_CR) ||
                   ((mode_i == lrc_pkg::MODE_NORMAL) && (count_i != '0));
      if (close_line) begin
        res0_o.kind = lrc_pkg::KindEol;
        res1_o.kind = lrc_pkg::KindDone;
        res1_o.last = 1'b1;
        num_o       = 2'd2;
      end else begin
        res0_o.kind = lrc_pkg::KindDone;
        res0_o.last = 1'b1;
        num_o       = 2'd1;
      end
      mode_o  = lrc_pkg::MODE_NORMAL;
      count_o = '0;
    end else begin
      case (mode_i)
        lrc_pkg::MODE_CR, lrc_pkg::MODE_BS_CR: begin
          // An LF right after CR belongs to the same line break.
          if (byte_i == lrc_pkg::ChLf) begin
            mode_o = lrc_pkg::MODE_NORMAL;
          end else begin
            normal_path = 1'b1;
          end
        end
        lrc_pkg::MODE_BS: begin
          if (byte_i == lrc_pkg::ChCr) begin
            mode_o = lrc_pkg::MODE_BS_CR;
          end else if (byte_i == lrc_pkg::ChLf) begin
            mode_o = lrc_pkg::MODE_NORMAL;
          end else begin
            mode_o = lrc_pkg::MODE_NORMAL;
            keep   = 1'b1;
          end
        end
        default: begin
          normal_path = 1'b1;
        end
      endcase

      if (normal_path) begin
        if (byte_i == lrc_pkg::ChCr) begin
          count_o     = '0;
          mode_o      = lrc_pkg::MODE_CR;
          res0_o.kind = lrc_pkg::KindEol;
          res0_o.last = 1'b1;
          num_o       = 2'd1;
        end else if (byte_i == lrc_pkg::ChLf) begin
          count_o     = '0;
          mode_o      = lrc_pkg::MODE_NORMAL;
          res0_o.kind = lrc_pkg::KindEol;
          res0_o.last = 1'b1;
          num_o       = 2'd1;
        end else if (byte_i == lrc_pkg::ChBs) begin
          mode_o = lrc_pkg::MODE_BS;
        end else begin
          mode_o = lrc_pkg::MODE_NORMAL;
          keep   = 1'b1;
        end
      end

      if (keep && can_keep) begin
        count_o     = count_i + COUNT_BITS'(1);
        res0_o.data = byte_i;
        res0_o.kind = lrc_pkg::KindChar;
        res0_o.last = 1'b1;
        num_o       = 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/line_reader_with_continuation.sv -----
// Channel   Direction  Handshake              Word
// in        input      in_valid_i/in_stall_o  in_byte_i, end_of_file_i
// out       output     out_valid_o/out_stall_i out_byte_o, kind_o, last_of_run_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_data_i (max_line_chars)
//
// Each input word is scanned in the cycle it is accepted; its results appear on the
// output from the next cycle. One word per cycle is sustained while the output is not
// stalled and each word yields at most one result; an end-of-file word that yields two
// results fills the two-entry result buffer and stalls input until one has left. Reset
// clears the scan state and the buffer and loads a capacity of 1023. A stalled output
// holds its word, and input is stalled only when the buffer could not take two results.
`default_nettype none

module line_reader_with_continuation #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [7:0]                         in_byte_i,
  input  wire logic                               end_of_file_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [7:0]                              out_byte_o,
  output logic [1:0]                              kind_o,
  output logic                                    last_of_run_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [lrc_pkg::MaxCharsWidth-1:0]  cfg_data_i
);

  logic [lrc_pkg::MaxCharsWidth-1:0] max_chars_q;
  lrc_pkg::scan_mode_e               mode_q, mode_d;
  logic [COUNT_BITS-1:0]             count_q, count_d;
  logic [1:0]                        fill_q, fill_d;
  lrc_pkg::result_t                  head_q, head_d, tail_q, tail_d;
  lrc_pkg::result_t                  res0, res1;
  logic [1:0]                        num_res;
  logic                              accept;
  logic                              pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= lrc_pkg::MaxCharsReset;
    end else if (cfg_valid_i) begin
      max_chars_q <= cfg_data_i;
    end
  end

  lrc_scan #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .byte_i      (in_byte_i),
    .eof_i       (end_of_file_i),
    .mode_i      (mode_q),
    .count_i     (count_q),
    .max_chars_i (max_chars_q),
    .mode_o      (mode_d),
    .count_o     (count_d),
    .num_o       (num_res),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  assign out_valid_o = (fill_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  // The buffer must be empty once this cycle's pop is done, so two results always fit.
  assign in_stall_o  = !((fill_q == 2'd0) || ((fill_q == 2'd1) && !out_stall_i));
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    fill_d = fill_q;
    head_d = head_q;
    tail_d = tail_q;
    if (accept) begin
      fill_d = num_res;
      head_d = res0;
      tail_d = res1;
    end else if (pop) begin
      fill_d = fill_q - 2'd1;
      head_d = tail_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lrc_pkg::MODE_NORMAL;
      count_q <= '0;
      fill_q  <= 2'd0;
    end else begin
      fill_q <= fill_d;
      if (accept) begin
        mode_q  <= mode_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign out_byte_o    = head_q.data;
  assign kind_o        = head_q.kind;
  assign last_of_run_o = head_q.last;

endmodule

`default_nettype wire

// ----- hdl/lrc_check.sv -----
`default_nettype none

module lrc_check (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic [1:0] kind_o,
  input wire logic       last_of_run_o
);

  // A stalled result word holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(kind_o) && $stable(last_of_run_o))
    else $error("stalled result word changed");

  // Only line characters carry a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != lrc_pkg::KindChar) |-> (out_byte_o == 8'd0))
    else $error("non-character result carries a byte");

  // The end-of-stream report always closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == lrc_pkg::KindDone) |-> last_of_run_o)
    else $error("end-of-stream result is not last of its run");

  // An end of line that is not last belongs to end of file and is followed by the report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (kind_o == lrc_pkg::KindEol) && !last_of_run_o |=>
    out_valid_o && (kind_o == lrc_pkg::KindDone) && last_of_run_o)
    else $error("end of line before end of stream not followed by the report");

  // Character results always come one per input word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == lrc_pkg::KindChar) |-> last_of_run_o)
    else $error("character result is not last of its run");

endmodule

bind line_reader_with_continuation lrc_check u_lrc_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_byte_o    (out_byte_o),
  .kind_o        (kind_o),
  .last_of_run_o (last_of_run_o)
);

`default_nettype wire
